@@ hw/rtl/fre_pkg.sv @@
package fre_pkg;

  // Record counter width; record_index carries its low RIDX_OUT_W bits.
  localparam int RECORD_INDEX_BITS = 16;
  localparam int RIDX_OUT_W        = 16;

  // seq_kind codes
  localparam logic [1:0] SEQ_DNA     = 2'd0;
  localparam logic [1:0] SEQ_RNA     = 2'd1;
  localparam logic [1:0] SEQ_PROTEIN = 2'd2;

  // Byte values the parser and encoder care about
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic signed [7:0] PROT_STAR    = 8'sd1;
  localparam logic signed [7:0] PROT_UNKNOWN = 8'sd101;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]       residue_code;
    logic [RIDX_OUT_W-1:0]   record_index;
    logic                    record_first;
  } out_item_t;

  // Parser decision for the item in the input register
  typedef struct packed {
    logic                    emit;
    logic                    first;
    logic [RIDX_OUT_W-1:0]   index;
  } parse_res_t;

  // Amino acid code for uppercase letter A..Z, given as offset from 'A'
  function automatic logic signed [7:0] prot_upper(input logic [4:0] idx);
    logic signed [7:0] v;
    case (idx)
      5'd0:  v = 8'sd2;
      5'd1:  v = 8'sd73;
      5'd2:  v = 8'sd11;
      5'd3:  v = 8'sd7;
      5'd4:  v = 8'sd13;
      5'd5:  v = 8'sd43;
      5'd6:  v = 8'sd19;
      5'd7:  v = 8'sd23;
      5'd8:  v = 8'sd29;
      5'd9:  v = 8'sd83;
      5'd10: v = 8'sd37;
      5'd11: v = 8'sd31;
      5'd12: v = 8'sd41;
      5'd13: v = 8'sd5;
      5'd14: v = 8'sd97;
      5'd15: v = 8'sd47;
      5'd16: v = 8'sd17;
      5'd17: v = 8'sd3;
      5'd18: v = 8'sd53;
      5'd19: v = 8'sd59;
      5'd20: v = 8'sd89;
      5'd21: v = 8'sd71;
      5'd22: v = 8'sd61;
      5'd23: v = 8'sd101;
      5'd24: v = 8'sd67;
      5'd25: v = 8'sd79;
      default: v = PROT_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/fre_encoder.sv @@
module fre_encoder (
  input  logic [7:0]        in_byte,
  input  logic [1:0]        seq_kind,
  output logic signed [7:0] residue_code
);
  import fre_pkg::*;

  logic              is_lower;
  logic              is_upper;
  logic [7:0]        up;
  logic [7:0]        ofs;
  logic signed [7:0] nuc_base;
  logic signed [7:0] nuc;
  logic signed [7:0] prot;

  always_comb begin
    is_lower = (in_byte >= CH_LA) && (in_byte <= CH_LZ);
    is_upper = (in_byte >= CH_UA) && (in_byte <= CH_UZ);
    up       = is_lower ? (in_byte - CASE_OFS) : in_byte;
    ofs      = up - CH_UA;

    case (up)
      CH_UA:        nuc_base = 8'sd1;
      CH_UG:        nuc_base = 8'sd2;
      CH_UT, CH_UU: nuc_base = -8'sd1;
      CH_UC:        nuc_base = -8'sd2;
      CH_UN:        nuc_base = 8'sd3;
      default:      nuc_base = 8'sd0;
    endcase
    // lowercase masking: times five as shift and add
    nuc = is_lower ? ((nuc_base <<< 2) + nuc_base) : nuc_base;

    if (in_byte == CH_STAR) begin
      prot = PROT_STAR;
    end else if (is_upper) begin
      prot = prot_upper(ofs[4:0]);
    end else if (is_lower) begin
      prot = -prot_upper(ofs[4:0]);
    end else begin
      prot = PROT_UNKNOWN;
    end

    residue_code = (seq_kind == SEQ_PROTEIN) ? prot : nuc;
  end

endmodule

@@ hw/rtl/fre_parser.sv @@
module fre_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  fre_pkg::in_item_t item,
  output fre_pkg::parse_res_t res
);
  import fre_pkg::*;

  logic                         at_line_start, at_line_start_next;
  logic                         in_header_line, in_header_line_next;
  logic                         header_seen, header_seen_next;
  logic                         record_has_residue, record_has_residue_next;
  logic [RECORD_INDEX_BITS-1:0] next_record_number, next_record_number_next;
  logic                         blank;

  always_comb begin
    blank = (item.in_byte == CH_SPACE) ||
            ((item.in_byte >= CH_TAB) && (item.in_byte <= CH_CR));

    at_line_start_next      = at_line_start;
    in_header_line_next     = in_header_line;
    header_seen_next        = header_seen;
    record_has_residue_next = record_has_residue;
    next_record_number_next = next_record_number;
    res.emit                = 1'b0;
    res.first               = !record_has_residue;
    res.index               = RIDX_OUT_W'(next_record_number);

    if (item.file_end) begin
      at_line_start_next      = 1'b1;
      in_header_line_next     = 1'b0;
      header_seen_next        = 1'b0;
      record_has_residue_next = 1'b0;
      next_record_number_next = '0;
    end else if (item.in_byte == CH_LF) begin
      at_line_start_next  = 1'b1;
      in_header_line_next = 1'b0;
    end else begin
      at_line_start_next = 1'b0;
      if (at_line_start && (item.in_byte == CH_GT)) begin
        // empty records do not use up an index
        if (header_seen && record_has_residue) begin
          next_record_number_next = next_record_number + 1'b1;
        end
        header_seen_next        = 1'b1;
        in_header_line_next     = 1'b1;
        record_has_residue_next = 1'b0;
      end else if (!in_header_line && header_seen && !blank) begin
        res.emit                = 1'b1;
        record_has_residue_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start      <= 1'b1;
      in_header_line     <= 1'b0;
      header_seen        <= 1'b0;
      record_has_residue <= 1'b0;
      next_record_number <= '0;
    end else if (step) begin
      at_line_start      <= at_line_start_next;
      in_header_line     <= in_header_line_next;
      header_seen        <= header_seen_next;
      record_has_residue <= record_has_residue_next;
      next_record_number <= next_record_number_next;
    end
  end

endmodule

@@ hw/rtl/fasta_residue_encoder.sv @@
// A byte accepted into the input register s1_item is parsed and encoded there; its residue loads
// into out_item once the result register is free, and is offered from out_item with out_valid.
// Throughput: one byte per cycle; the input register, the parser flags and the
// result register all advance together when the result register is free.
// Bytes that give no residue (headers, line ends, whitespace, end of file) never stall.
// Reset (rst, synchronous): both registers empty, parser at line start with no
// record open, record counter zero, seq_kind DNA.
module fasta_residue_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fre_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fre_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data
);
  import fre_pkg::*;

  logic              seq_kind;
  logic [1:0]        seq_kind_reg;
  logic              s1_valid;
  in_item_t          s1_item;
  logic              s1_step;
  logic              out_free;
  parse_res_t        res;
  logic signed [7:0] code;

  assign seq_kind = (seq_kind_reg == SEQ_PROTEIN);

  fre_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (s1_step),
    .item (s1_item),
    .res  (res)
  );

  fre_encoder u_encoder (
    .in_byte      (s1_item.in_byte),
    .seq_kind     (seq_kind_reg),
    .residue_code (code)
  );

  assign out_free = !out_valid || out_ready;
  // hold the input register only when it has a residue and the result slot is full
  assign s1_step  = s1_valid && (!res.emit || out_free);
  assign in_ready = !s1_valid || s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_kind_reg <= SEQ_DNA;
    end else if (cfg_we) begin
      seq_kind_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_step && res.emit) begin
      out_item.residue_code <= code;
      out_item.record_index <= res.index;
      out_item.record_first <= res.first;
    end
  end

  a_empty_stage_ready : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input register empty but not ready");

  a_code_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.residue_code >= -8'sd101) &&
                  (out_item.residue_code <= 8'sd101))
    else $error("residue code out of range");

  a_nuc_codes : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !seq_kind) |->
      (out_item.residue_code == 8'sd0)  || (out_item.residue_code == 8'sd1) ||
      (out_item.residue_code == 8'sd2)  || (out_item.residue_code == 8'sd3) ||
      (out_item.residue_code == -8'sd1) || (out_item.residue_code == -8'sd2) ||
      (out_item.residue_code == 8'sd5)  || (out_item.residue_code == 8'sd10) ||
      (out_item.residue_code == 8'sd15) || (out_item.residue_code == -8'sd5) ||
      (out_item.residue_code == -8'sd10))
    else $error("nucleotide code not in table");

  a_no_drop : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.emit && out_valid && !out_ready) |=> s1_valid)
    else $error("residue dropped while result stalled");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fre_pkg::*;

  localparam int WATCHDOG_LIMIT         = 3000;
  localparam int SETTLE_CYCLES          = 4;
  localparam int LONG_HOLD_CYCLES       = 300;
  localparam int RANDOM_BYTES_PER_PHASE = 345;
  localparam logic [1:0] SEQ_SPARE      = 2'd3;
  localparam logic [7:0] CH_VT          = 8'h0B;
  localparam logic [7:0] CH_FF          = 8'h0C;

  class encoded_residue_tracker;
    logic [1:0] seq_kind;
    bit at_line_start;
    bit in_header;
    bit header_seen;
    bit has_residue;
    logic [RECORD_INDEX_BITS-1:0] record_no;
    int amino_prime[26];
    out_item_t awaited_residues[$];
    int residues_checked;
    int failures;
    int file_ends;

    function new();
      amino_prime = '{2, 73, 11, 7, 13, 43, 19, 23, 29, 83, 37, 31, 41,
                      5, 97, 47, 17, 3, 53, 59, 89, 71, 61, 101, 67, 79};
      seq_kind = SEQ_DNA;
      residues_checked = 0;
      failures = 0;
      file_ends = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      at_line_start = 1'b1;
      in_header = 1'b0;
      header_seen = 1'b0;
      has_residue = 1'b0;
      record_no = '0;
    endfunction

    function void set_kind(logic [1:0] kind);
      seq_kind = kind;
    endfunction

    function int pending();
      return awaited_residues.size();
    endfunction

    function logic signed [7:0] nucleotide_code(logic [7:0] b);
      logic [7:0] up;
      int scale;
      int base;
      up = b;
      scale = 1;
      // lowercase marks a masked base: five times the uppercase value
      if (b >= CH_LA && b <= CH_LZ) begin
        up = b - CASE_OFS;
        scale = 5;
      end
      case (up)
        CH_UA: base = 1;
        CH_UG: base = 2;
        CH_UT, CH_UU: base = -1;
        CH_UC: base = -2;
        CH_UN: base = 3;
        default: base = 0;
      endcase
      return 8'(base * scale);
    endfunction

    function logic signed [7:0] protein_code(logic [7:0] b);
      if (b == CH_STAR) return PROT_STAR;
      if (b >= CH_UA && b <= CH_UZ) return 8'(amino_prime[b - CH_UA]);
      if (b >= CH_LA && b <= CH_LZ) return 8'(-amino_prime[b - CH_LA]);
      return PROT_UNKNOWN;
    endfunction

    function void take_byte(in_item_t it);
      bit was_line_start;
      bit blank;
      out_item_t res;
      was_line_start = at_line_start;
      blank = (it.in_byte == CH_SPACE) || (it.in_byte >= CH_TAB && it.in_byte <= CH_CR);
      if (it.file_end) begin
        file_ends++;
        clear_parser();
        return;
      end
      if (it.in_byte == CH_LF) begin
        at_line_start = 1'b1;
        in_header = 1'b0;
        return;
      end
      at_line_start = 1'b0;
      if (was_line_start && it.in_byte == CH_GT) begin
        // empty records keep their number for the next one
        if (header_seen && has_residue) begin
          record_no = record_no + 1'b1;
        end
        header_seen = 1'b1;
        in_header = 1'b1;
        has_residue = 1'b0;
        return;
      end
      if (in_header || !header_seen || blank) return;
      res.residue_code = (seq_kind == SEQ_PROTEIN) ? protein_code(it.in_byte)
                                                   : nucleotide_code(it.in_byte);
      res.record_index = record_no[RIDX_OUT_W-1:0];
      res.record_first = !has_residue;
      has_residue = 1'b1;
      awaited_residues.push_back(res);
    endfunction

    function void match_residue(out_item_t got);
      out_item_t want;
      if (awaited_residues.size() == 0) begin
        $error("residue with no byte behind it: code %0d, record %0d, first %0b",
               got.residue_code, got.record_index, got.record_first);
        failures++;
        return;
      end
      want = awaited_residues.pop_front();
      residues_checked++;
      if (got.residue_code !== want.residue_code) begin
        $error("residue_code: expected %0d, got %0d", want.residue_code, got.residue_code);
        failures++;
      end
      if (got.record_index !== want.record_index) begin
        $error("record_index: expected %0d, got %0d", want.record_index, got.record_index);
        failures++;
      end
      if (got.record_first !== want.record_first) begin
        $error("record_first: expected %0b, got %0b", want.record_first, got.record_first);
        failures++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  encoded_residue_tracker residues = new();

  fasta_residue_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) residues.take_byte(in_item);
      if (out_valid && out_ready) residues.match_residue(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $error("no transaction for %0d cycles", quiet_cycles);
          $display("** fasta_residue_encoder: FAILED **");
          $finish;
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high for a back-to-back byte.
  task automatic send_byte(input logic [7:0] b, input logic fe = 1'b0);
    in_item_t item;
    item.in_byte = b;
    item.file_end = fe;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic set_seq_kind(input logic [1:0] kind);
    in_valid <= 1'b0;
    while (residues.pending() != 0) @(negedge clk);
    // let bytes that give no residue clear the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= kind;
    @(negedge clk);
    cfg_we <= 1'b0;
    residues.set_kind(kind);
  endtask

  function automatic logic [7:0] residue_byte();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 35) begin
      case ($urandom_range(5))
        0: b = CH_UA;
        1: b = CH_UC;
        2: b = CH_UG;
        3: b = CH_UT;
        4: b = CH_UU;
        default: b = CH_UN;
      endcase
      if ($urandom_range(1)) b = b + CASE_OFS;
    end else if (pick < 65) begin
      b = CH_UA + 8'($urandom_range(25));
      if ($urandom_range(1)) b = b + CASE_OFS;
    end else if (pick < 70) begin
      b = CH_STAR;
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0: b = CH_SPACE;
        1: b = CH_TAB;
        2: b = CH_VT;
        3: b = CH_FF;
        default: b = CH_CR;
      endcase
    end else if (pick < 84) begin
      b = CH_GT;
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  function automatic logic [7:0] header_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_LF);
    return b;
  endfunction

  task automatic send_sequence_line();
    repeat ($urandom_range(15, 1)) send_byte(residue_byte());
    if ($urandom_range(3) == 0) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_random_file();
    if ($urandom_range(9) == 0) begin
      // raw noise with the odd end of file
      repeat ($urandom_range(40, 5))
        send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
      return;
    end
    if ($urandom_range(4) == 0) send_sequence_line();
    repeat ($urandom_range(6, 1)) begin
      send_byte(CH_GT);
      repeat ($urandom_range(6)) send_byte(header_byte());
      send_byte(CH_LF);
      if ($urandom_range(7) != 0) begin
        repeat ($urandom_range(3, 1)) send_sequence_line();
      end
    end
    if ($urandom_range(4) != 0) send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_directed();
    logic [7:0] dna_probe [25];
    logic [7:0] protein_probe [6];
    dna_probe = '{CH_UT, CH_LF, CH_GT, 8'hFF, CH_LF,
                  CH_LA, CH_UG, CH_UT + CASE_OFS, CH_UU + CASE_OFS, CH_UC,
                  CH_UN + CASE_OFS, 8'h00, CH_SPACE, CH_TAB, CH_CR,
                  CH_VT, CH_FF, CH_UA, CH_GT, CH_LF,
                  CH_GT, CH_LF, CH_GT, CH_LF, CH_UG + CASE_OFS};
    protein_probe = '{CH_GT, CH_LF, CH_STAR, CH_UZ, CH_LA, 8'hFF};
    set_seq_kind(SEQ_DNA);
    foreach (dna_probe[i]) send_byte(dna_probe[i]);
    send_byte(CH_GT, 1'b1);
    set_seq_kind(SEQ_PROTEIN);
    foreach (protein_probe[i]) send_byte(protein_probe[i]);
    send_byte(CH_GT, 1'b1);
  endtask

  initial begin : stimulus
    logic [1:0] phase_kind [5];
    int phase_send_idle [5];
    int phase_recv_stall [5];
    int target;
    phase_kind = '{SEQ_RNA, SEQ_PROTEIN, SEQ_DNA, SEQ_SPARE, SEQ_PROTEIN};
    phase_send_idle = '{0, 83, 0, 35, 0};
    phase_recv_stall = '{0, 0, 83, 35, 0};
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    run_directed();

    for (int p = 0; p < 5; p++) begin
      send_idle_pct = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      set_seq_kind(phase_kind[p]);
      // hold the output off while bytes keep coming, so the input backs up
      if (p == 0) hold_requests++;
      target = bytes_sent + RANDOM_BYTES_PER_PHASE;
      while (bytes_sent < target) send_random_file();
    end

    in_valid <= 1'b0;
    while (residues.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Checked %0d residues from %0d bytes over %0d file ends, seq_kind 0 through 3.",
             residues.residues_checked, bytes_sent, residues.file_ends);
    $display("Idle and stall mixes plus one long output hold-off that backed up the input.");
    if (residues.failures == 0) begin
      $display("** fasta_residue_encoder: PASSED **");
    end else begin
      $display("** fasta_residue_encoder: FAILED **");
    end
    $finish;
  end

endmodule
